// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the load/store unit RTL.
// Standalone header; no dependencies. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// clocked check, disabled while reset is asserted (active low)
`define LSU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("load/store unit assertion failed");
// clocked check that also holds during reset
`define LSU_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("load/store unit assertion failed");
`else
`define LSU_ASSERT(lbl, clk, rst_n, prop)
`define LSU_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: hw/rtl/lsu_pkg.sv
// Types, codes and opcode constants of the load/store unit.
// No dependencies; imported by every module of the block.
package lsu_pkg;

    localparam int NUM_SLOTS = 3;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_DONE  = 2'd2,
        KIND_ERROR = 2'd3
    } lsu_kind_t;

    typedef enum logic [2:0] {
        PEND_NONE = 3'b001,
        PEND_LOAD = 3'b010,
        PEND_POP  = 3'b100
    } lsu_pend_t;

    localparam logic [2:0] REG_B   = 3'd0;
    localparam logic [2:0] REG_C   = 3'd1;
    localparam logic [2:0] REG_D   = 3'd2;
    localparam logic [2:0] REG_E   = 3'd3;
    localparam logic [2:0] REG_H   = 3'd4;
    localparam logic [2:0] REG_L   = 3'd5;
    localparam logic [2:0] REG_MEM = 3'd6;
    localparam logic [2:0] REG_A   = 3'd7;

    localparam logic [1:0] PAIR_BC = 2'd0;
    localparam logic [1:0] PAIR_DE = 2'd1;
    localparam logic [1:0] PAIR_HL = 2'd2;
    localparam logic [1:0] PAIR_AF = 2'd3;

    localparam logic [7:0] OP_LD_A_BC   = 8'h0a;
    localparam logic [7:0] OP_LD_A_DE   = 8'h1a;
    localparam logic [7:0] OP_LD_A_NN   = 8'hfa;
    localparam logic [7:0] OP_LDH_A_C   = 8'hf2;
    localparam logic [7:0] OP_LDH_A_N   = 8'hf0;
    localparam logic [7:0] OP_LD_BC_A   = 8'h02;
    localparam logic [7:0] OP_LD_DE_A   = 8'h12;
    localparam logic [7:0] OP_LD_NN_A   = 8'hea;
    localparam logic [7:0] OP_LDH_C_A   = 8'he2;
    localparam logic [7:0] OP_LDH_N_A   = 8'he0;
    localparam logic [7:0] OP_LD_HL_SPE = 8'hf8;
    localparam logic [7:0] OP_PUSH_BC   = 8'hc5;
    localparam logic [7:0] OP_PUSH_DE   = 8'hd5;
    localparam logic [7:0] OP_PUSH_HL   = 8'he5;
    localparam logic [7:0] OP_PUSH_AF   = 8'hf5;
    localparam logic [7:0] OP_POP_BC    = 8'hc1;
    localparam logic [7:0] OP_POP_DE    = 8'hd1;
    localparam logic [7:0] OP_POP_HL    = 8'he1;
    localparam logic [7:0] OP_POP_AF    = 8'hf1;
    localparam logic [7:0] OP_HALT      = 8'h76;
    localparam logic [1:0] OP_GRP_LD_RR = 2'b01;

    localparam logic [7:0] HIGH_PAGE = 8'hff;

    localparam logic CMD_EXEC = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] opcode;
        logic [7:0] imm_low;
        logic [7:0] imm_high;
        logic [7:0] read_data;
    } lsu_in_t;

    typedef struct packed {
        lsu_kind_t   kind;
        logic [15:0] mem_address;
        logic [7:0]  write_byte;
        logic        last;
        logic [7:0]  acc_out;
        logic [15:0] bc_out;
        logic [15:0] de_out;
        logic [15:0] hl_out;
        logic [15:0] sp_out;
        logic [3:0]  flags_out;
    } lsu_out_t;

    typedef struct packed {
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  c;
        logic [7:0]  d;
        logic [7:0]  e;
        logic [7:0]  h;
        logic [7:0]  l;
        logic [15:0] sp;
        logic [3:0]  flags;
        lsu_pend_t   pend;
        logic [2:0]  pend_dest;
        logic [1:0]  reads_left;
        logic [7:0]  first_byte;
    } lsu_regs_t;

    typedef struct packed {
        logic [1:0]                        count;
        lsu_kind_t [NUM_SLOTS-1:0]         kind;
        logic [NUM_SLOTS-1:0][15:0]        addr;
        logic [NUM_SLOTS-1:0][7:0]         data;
    } lsu_batch_t;

endpackage

// File: hw/rtl/lsu_exec.sv
// Combinational execute logic: one request against the register file gives the
// next register file and the batch of up to three results. Depends on lsu_pkg.
module lsu_exec
    import lsu_pkg::*;
(
    input  lsu_in_t    req,
    input  lsu_regs_t  regs,
    output lsu_regs_t  regs_next,
    output lsu_batch_t batch
);

    function automatic logic [7:0] get_reg(lsu_regs_t r, logic [2:0] code);
        logic [7:0] v;
        case (code)
            REG_B:   v = r.b;
            REG_C:   v = r.c;
            REG_D:   v = r.d;
            REG_E:   v = r.e;
            REG_H:   v = r.h;
            REG_L:   v = r.l;
            REG_A:   v = r.a;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic lsu_regs_t set_reg(lsu_regs_t r, logic [2:0] code, logic [7:0] v);
        lsu_regs_t o;
        o = r;
        case (code)
            REG_B:   o.b = v;
            REG_C:   o.c = v;
            REG_D:   o.d = v;
            REG_E:   o.e = v;
            REG_H:   o.h = v;
            REG_L:   o.l = v;
            REG_A:   o.a = v;
            default: o = r;
        endcase
        return o;
    endfunction

    logic [7:0]  op;
    logic [7:0]  n1;
    logic [2:0]  dst;
    logic [2:0]  src;
    logic [15:0] bc;
    logic [15:0] de;
    logic [15:0] hl;
    logic [15:0] nn;
    logic [15:0] spe_sum;
    logic [8:0]  low_sum;
    logic [4:0]  nib_sum;
    logic [7:0]  push_lo;
    logic [7:0]  push_hi;
    logic [7:0]  pop_lo;
    logic [7:0]  pop_hi;

    assign op      = req.opcode;
    assign n1      = req.imm_low;
    assign dst     = op[5:3];
    assign src     = op[2:0];
    assign bc      = {regs.b, regs.c};
    assign de      = {regs.d, regs.e};
    assign hl      = {regs.h, regs.l};
    assign nn      = {req.imm_high, req.imm_low};
    assign spe_sum = regs.sp + {{8{n1[7]}}, n1};
    assign low_sum = {1'b0, regs.sp[7:0]} + {1'b0, n1};
    assign nib_sum = {1'b0, regs.sp[3:0]} + {1'b0, n1[3:0]};
    assign pop_lo  = regs.first_byte;
    assign pop_hi  = req.read_data;

    always_comb begin
        unique case (op[5:4])
            PAIR_BC: begin push_lo = regs.c; push_hi = regs.b; end
            PAIR_DE: begin push_lo = regs.e; push_hi = regs.d; end
            PAIR_HL: begin push_lo = regs.l; push_hi = regs.h; end
            PAIR_AF: begin push_lo = {regs.flags, 4'h0}; push_hi = regs.a; end
            default: begin push_lo = 8'h00; push_hi = 8'h00; end
        endcase
    end

    always_comb begin
        regs_next   = regs;
        batch.count = 2'd1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            batch.kind[i] = KIND_DONE;
            batch.addr[i] = 16'h0000;
            batch.data[i] = 8'h00;
        end

        if (req.command == CMD_DATA) begin
            if (regs.pend == PEND_LOAD && regs.reads_left == 2'd1) begin
                regs_next            = set_reg(regs, regs.pend_dest, req.read_data);
                regs_next.pend       = PEND_NONE;
                regs_next.reads_left = 2'd0;
            end else if (regs.pend == PEND_POP && regs.reads_left == 2'd2) begin
                regs_next.first_byte = req.read_data;
                regs_next.reads_left = 2'd1;
                batch.count          = 2'd0;
            end else if (regs.pend == PEND_POP && regs.reads_left == 2'd1) begin
                unique case (regs.pend_dest[1:0])
                    PAIR_BC: begin regs_next.b = pop_hi; regs_next.c = pop_lo; end
                    PAIR_DE: begin regs_next.d = pop_hi; regs_next.e = pop_lo; end
                    PAIR_HL: begin regs_next.h = pop_hi; regs_next.l = pop_lo; end
                    PAIR_AF: begin regs_next.a = pop_hi; regs_next.flags = pop_lo[7:4]; end
                    default: regs_next = regs;
                endcase
                regs_next.sp         = regs.sp + 16'd2;
                regs_next.pend       = PEND_NONE;
                regs_next.reads_left = 2'd0;
            end else begin
                batch.kind[0] = KIND_ERROR;
            end
        end else if (regs.pend != PEND_NONE) begin
            // new instruction abandons the outstanding read
            regs_next.pend       = PEND_NONE;
            regs_next.reads_left = 2'd0;
            batch.kind[0]        = KIND_ERROR;
        end else if (op[7:6] == OP_GRP_LD_RR && op != OP_HALT) begin
            if (src == REG_MEM) begin
                regs_next.pend       = PEND_LOAD;
                regs_next.pend_dest  = dst;
                regs_next.reads_left = 2'd1;
                batch.kind[0]        = KIND_READ;
                batch.addr[0]        = hl;
            end else if (dst == REG_MEM) begin
                batch.count   = 2'd2;
                batch.kind[0] = KIND_WRITE;
                batch.addr[0] = hl;
                batch.data[0] = get_reg(regs, src);
            end else begin
                regs_next = set_reg(regs, dst, get_reg(regs, src));
            end
        end else begin
            unique case (op) inside
                OP_LD_A_BC, OP_LD_A_DE, OP_LD_A_NN, OP_LDH_A_C, OP_LDH_A_N: begin
                    regs_next.pend       = PEND_LOAD;
                    regs_next.pend_dest  = REG_A;
                    regs_next.reads_left = 2'd1;
                    batch.kind[0]        = KIND_READ;
                    case (op)
                        OP_LD_A_BC: batch.addr[0] = bc;
                        OP_LD_A_DE: batch.addr[0] = de;
                        OP_LD_A_NN: batch.addr[0] = nn;
                        OP_LDH_A_C: batch.addr[0] = {HIGH_PAGE, regs.c};
                        default:    batch.addr[0] = {HIGH_PAGE, n1};
                    endcase
                end
                OP_LD_BC_A, OP_LD_DE_A, OP_LD_NN_A, OP_LDH_C_A, OP_LDH_N_A: begin
                    batch.count   = 2'd2;
                    batch.kind[0] = KIND_WRITE;
                    batch.data[0] = regs.a;
                    case (op)
                        OP_LD_BC_A: batch.addr[0] = bc;
                        OP_LD_DE_A: batch.addr[0] = de;
                        OP_LD_NN_A: batch.addr[0] = nn;
                        OP_LDH_C_A: batch.addr[0] = {HIGH_PAGE, regs.c};
                        default:    batch.addr[0] = {HIGH_PAGE, n1};
                    endcase
                end
                OP_LD_HL_SPE: begin
                    regs_next.flags = {2'b00, nib_sum[4], low_sum[8]};
                    regs_next.h     = spe_sum[15:8];
                    regs_next.l     = spe_sum[7:0];
                end
                OP_PUSH_BC, OP_PUSH_DE, OP_PUSH_HL, OP_PUSH_AF: begin
                    regs_next.sp  = regs.sp - 16'd2;
                    batch.count   = 2'd3;
                    batch.kind[0] = KIND_WRITE;
                    batch.addr[0] = regs.sp - 16'd2;
                    batch.data[0] = push_lo;
                    batch.kind[1] = KIND_WRITE;
                    batch.addr[1] = regs.sp - 16'd1;
                    batch.data[1] = push_hi;
                end
                OP_POP_BC, OP_POP_DE, OP_POP_HL, OP_POP_AF: begin
                    regs_next.pend       = PEND_POP;
                    regs_next.pend_dest  = {1'b0, op[5:4]};
                    regs_next.reads_left = 2'd2;
                    batch.count          = 2'd2;
                    batch.kind[0]        = KIND_READ;
                    batch.addr[0]        = regs.sp;
                    batch.kind[1]        = KIND_READ;
                    batch.addr[1]        = regs.sp + 16'd1;
                end
                default: begin
                    batch.kind[0] = KIND_ERROR;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/lsu_state.sv
// Architectural register file and outstanding-read tracking, updated once per
// accepted request. Depends on lsu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lsu_state
    import lsu_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      update,
    input  lsu_regs_t regs_next,
    output lsu_regs_t regs
);

    lsu_regs_t regs_reg;
    lsu_regs_t regs_init;

    always_comb begin
        regs_init      = '0;
        regs_init.pend = PEND_NONE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg <= regs_init;
        end else if (update) begin
            regs_reg <= regs_next;
        end
    end

    assign regs = regs_reg;

    `LSU_ASSERT(a_idle_no_reads, aclk, aresetn, regs_reg.pend == PEND_NONE |-> regs_reg.reads_left == 2'd0)
    `LSU_ASSERT(a_load_one_read, aclk, aresetn, regs_reg.pend == PEND_LOAD |-> regs_reg.reads_left == 2'd1)
    `LSU_ASSERT(a_pop_reads, aclk, aresetn, regs_reg.pend == PEND_POP |-> regs_reg.reads_left != 2'd0)

endmodule

// File: hw/rtl/lsu_result_buf.sv
// Result register: holds the batch of one request and hands its results out one per
// cycle while m_ready is high, with the register snapshot. Depends on lsu_pkg, assert_macros.svh.
`include "assert_macros.svh"

module lsu_result_buf
    import lsu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  lsu_batch_t batch,
    input  lsu_regs_t  regs,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output lsu_out_t   m_payload
);

    logic [1:0]                 total_reg;
    logic [1:0]                 total_next;
    logic [1:0]                 pos_reg;
    logic [1:0]                 pos_next;
    lsu_kind_t [NUM_SLOTS-1:0]  kind_reg;
    logic [NUM_SLOTS-1:0][15:0] addr_reg;
    logic [NUM_SLOTS-1:0][7:0]  data_reg;
    logic                       is_last;
    logic                       take;

    assign m_valid = total_reg != 2'd0;
    assign is_last = pos_reg == (total_reg - 2'd1);
    assign take    = m_valid && m_ready;
    assign s_ready = !m_valid || (take && is_last);

    always_comb begin
        total_next = total_reg;
        pos_next   = pos_reg;
        if (load) begin
            total_next = batch.count;
            pos_next   = 2'd0;
        end else if (take) begin
            if (is_last) begin
                total_next = 2'd0;
                pos_next   = 2'd0;
            end else begin
                pos_next = pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= 2'd0;
            pos_reg   <= 2'd0;
        end else begin
            total_reg <= total_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg <= batch.kind;
            addr_reg <= batch.addr;
            data_reg <= batch.data;
        end
    end

    // register file only changes when a new batch loads, so it is the snapshot
    always_comb begin
        m_payload.kind        = kind_reg[pos_reg];
        m_payload.mem_address = addr_reg[pos_reg];
        m_payload.write_byte  = data_reg[pos_reg];
        m_payload.last        = is_last;
        m_payload.acc_out     = regs.a;
        m_payload.bc_out      = {regs.b, regs.c};
        m_payload.de_out      = {regs.d, regs.e};
        m_payload.hl_out      = {regs.h, regs.l};
        m_payload.sp_out      = regs.sp;
        m_payload.flags_out   = regs.flags;
    end

    `LSU_ASSERT(a_load_shows, aclk, aresetn, load && batch.count != 2'd0 |=> m_valid && pos_reg == 2'd0)
    `LSU_ASSERT(a_pos_range, aclk, aresetn, m_valid |-> pos_reg < total_reg)
    `LSU_ASSERT(a_drain, aclk, aresetn, take && is_last && !load |=> !m_valid)

endmodule

// File: hw/rtl/lr35902_load_store_unit.sv
// Load/store unit: register file with LD, LDH, LD HL,SP+e, PUSH and POP.
// Depends on lsu_pkg, lsu_exec, lsu_state and lsu_result_buf.
//
// A request is executed in the cycle it is accepted: the register file updates
// and all of its results (up to three) are loaded into the result register.
// Results leave one per cycle on the m_ channel while m_ready is high, each with
// the register file as it stands after the request. A new request is taken in
// the same cycle as the final result of the previous one, so a request holds the
// result port until its last result is taken; the first data byte of a POP gives
// no result. Throughput is one request per cycle for single-result requests while
// m_ready is high, set by the single result register. Memory read data comes back
// as requests with command set, in the order the reads were issued.
module lr35902_load_store_unit
    import lsu_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  lsu_in_t  s_payload,
    output logic     m_valid,
    input  logic     m_ready,
    output lsu_out_t m_payload
);

    logic       s_fire;
    lsu_regs_t  regs;
    lsu_regs_t  regs_next;
    lsu_batch_t batch;

    assign s_fire = s_valid && s_ready;

    lsu_exec u_exec (
        .req       (s_payload),
        .regs      (regs),
        .regs_next (regs_next),
        .batch     (batch)
    );

    lsu_state u_state (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .update    (s_fire),
        .regs_next (regs_next),
        .regs      (regs)
    );

    lsu_result_buf u_result_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (s_fire),
        .batch     (batch),
        .regs      (regs),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

// File: tb/sv/lr35902_load_store_unit_test.sv
// Self-checking testbench for lr35902_load_store_unit: a queue-fed request driver,
// a result monitor and a shadow register file that predicts every result.
// Depends on lsu_pkg and the lr35902_load_store_unit RTL.
module lr35902_load_store_unit_test
    import lsu_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {
        PH_FLAT,
        PH_SRC_GAPS,
        PH_SINK_STALLS,
        PH_BOTH
    } phase_t;

    typedef struct {
        lsu_in_t req;
        phase_t  phase;
    } feed_item_t;

    typedef struct packed {
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  c;
        logic [7:0]  d;
        logic [7:0]  e;
        logic [7:0]  h;
        logic [7:0]  l;
        logic [15:0] sp;
        logic [3:0]  flags;
    } reg_file_t;

    localparam int NUM_REQUESTS = 470;
    localparam int MAX_REPORTS  = 10;
    localparam logic [7:0] OP_UNUSED_D3 = 8'hd3;
    localparam logic [7:0] LISTED_OPS [20] = '{
        OP_LD_A_BC, OP_LD_A_DE, OP_LD_A_NN, OP_LDH_A_C, OP_LDH_A_N,
        OP_LD_BC_A, OP_LD_DE_A, OP_LD_NN_A, OP_LDH_C_A, OP_LDH_N_A,
        OP_LD_HL_SPE, OP_PUSH_BC, OP_PUSH_DE, OP_PUSH_HL, OP_PUSH_AF,
        OP_POP_BC, OP_POP_DE, OP_POP_HL, OP_POP_AF, OP_LD_HL_SPE
    };

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    lsu_in_t  s_payload = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    lsu_out_t m_payload;

    feed_item_t request_feed[$];
    lsu_out_t   replies_due[$];
    phase_t     cur_phase = PH_FLAT;
    int         mismatches = 0;

    // shadow CPU state
    reg_file_t  cpu = '0;
    lsu_pend_t  pend_kind = PEND_NONE;
    logic [2:0] pend_target = '0;
    logic [1:0] reads_owed = '0;
    logic [7:0] pop_low = '0;

    lr35902_load_store_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #5 aclk = ~aclk;

    function automatic int gap_pct(phase_t p);
        case (p)
            PH_SRC_GAPS: return 70;
            PH_BOTH:     return 27;
            default:     return 0;
        endcase
    endfunction

    function automatic int stall_pct(phase_t p);
        case (p)
            PH_SINK_STALLS: return 70;
            PH_BOTH:        return 27;
            default:        return 0;
        endcase
    endfunction

    function automatic logic [7:0] reg_value(logic [2:0] code);
        case (code)
            REG_B:   return cpu.b;
            REG_C:   return cpu.c;
            REG_D:   return cpu.d;
            REG_E:   return cpu.e;
            REG_H:   return cpu.h;
            REG_L:   return cpu.l;
            REG_A:   return cpu.a;
            default: return 8'h00;
        endcase
    endfunction

    task automatic set_reg(logic [2:0] code, logic [7:0] v);
        case (code)
            REG_B:   cpu.b = v;
            REG_C:   cpu.c = v;
            REG_D:   cpu.d = v;
            REG_E:   cpu.e = v;
            REG_H:   cpu.h = v;
            REG_L:   cpu.l = v;
            REG_A:   cpu.a = v;
            default: ;
        endcase
    endtask

    function automatic lsu_out_t reply(lsu_kind_t kind, logic [15:0] addr, logic [7:0] data);
        lsu_out_t r;
        r.kind        = kind;
        r.mem_address = addr;
        r.write_byte  = data;
        r.last        = 1'b0;
        r.acc_out     = cpu.a;
        r.bc_out      = {cpu.b, cpu.c};
        r.de_out      = {cpu.d, cpu.e};
        r.hl_out      = {cpu.h, cpu.l};
        r.sp_out      = cpu.sp;
        r.flags_out   = cpu.flags;
        return r;
    endfunction

    // Applies one accepted request to the shadow CPU and queues its results.
    task automatic step_cpu(lsu_in_t req);
        lsu_out_t    burst[$];
        logic [15:0] bc, de, hl, nn, sum, rd_addr, wr_addr;
        logic [8:0]  byte_sum;
        logic [4:0]  nib_sum;
        logic [7:0]  lo, hi, wr_data;
        logic [2:0]  dst, src, rd_dest;
        logic [1:0]  pair;
        bit          is_read, is_write;
        bc = {cpu.b, cpu.c};
        de = {cpu.d, cpu.e};
        hl = {cpu.h, cpu.l};
        nn = {req.imm_high, req.imm_low};
        dst = req.opcode[5:3];
        src = req.opcode[2:0];
        pair = req.opcode[5:4];
        is_read = 1'b0;
        is_write = 1'b0;
        rd_addr = '0;
        rd_dest = REG_A;
        wr_addr = '0;
        wr_data = cpu.a;
        if (req.command == CMD_DATA) begin
            if (pend_kind == PEND_LOAD && reads_owed == 2'd1) begin
                set_reg(pend_target, req.read_data);
                pend_kind = PEND_NONE;
                reads_owed = 2'd0;
                burst.push_back(reply(KIND_DONE, 16'h0000, 8'h00));
            end else if (pend_kind == PEND_POP && reads_owed == 2'd2) begin
                pop_low = req.read_data;
                reads_owed = 2'd1;
            end else if (pend_kind == PEND_POP && reads_owed == 2'd1) begin
                case (pend_target[1:0])
                    PAIR_BC: {cpu.b, cpu.c} = {req.read_data, pop_low};
                    PAIR_DE: {cpu.d, cpu.e} = {req.read_data, pop_low};
                    PAIR_HL: {cpu.h, cpu.l} = {req.read_data, pop_low};
                    default: begin
                        cpu.a = req.read_data;
                        cpu.flags = pop_low[7:4];
                    end
                endcase
                cpu.sp = cpu.sp + 16'd2;
                pend_kind = PEND_NONE;
                reads_owed = 2'd0;
                burst.push_back(reply(KIND_DONE, 16'h0000, 8'h00));
            end else begin
                burst.push_back(reply(KIND_ERROR, 16'h0000, 8'h00));
            end
        end else if (pend_kind != PEND_NONE) begin
            // execute while a read is outstanding drops the read
            pend_kind = PEND_NONE;
            reads_owed = 2'd0;
            burst.push_back(reply(KIND_ERROR, 16'h0000, 8'h00));
        end else if (req.opcode[7:6] == OP_GRP_LD_RR && req.opcode != OP_HALT) begin
            if (src == REG_MEM) begin
                is_read = 1'b1;
                rd_addr = hl;
                rd_dest = dst;
            end else if (dst == REG_MEM) begin
                is_write = 1'b1;
                wr_addr = hl;
                wr_data = reg_value(src);
            end else begin
                set_reg(dst, reg_value(src));
                burst.push_back(reply(KIND_DONE, 16'h0000, 8'h00));
            end
        end else begin
            case (req.opcode)
                OP_LD_A_BC: begin
                    is_read = 1'b1;
                    rd_addr = bc;
                end
                OP_LD_A_DE: begin
                    is_read = 1'b1;
                    rd_addr = de;
                end
                OP_LD_A_NN: begin
                    is_read = 1'b1;
                    rd_addr = nn;
                end
                OP_LDH_A_C: begin
                    is_read = 1'b1;
                    rd_addr = {HIGH_PAGE, cpu.c};
                end
                OP_LDH_A_N: begin
                    is_read = 1'b1;
                    rd_addr = {HIGH_PAGE, req.imm_low};
                end
                OP_LD_BC_A: begin
                    is_write = 1'b1;
                    wr_addr = bc;
                end
                OP_LD_DE_A: begin
                    is_write = 1'b1;
                    wr_addr = de;
                end
                OP_LD_NN_A: begin
                    is_write = 1'b1;
                    wr_addr = nn;
                end
                OP_LDH_C_A: begin
                    is_write = 1'b1;
                    wr_addr = {HIGH_PAGE, cpu.c};
                end
                OP_LDH_N_A: begin
                    is_write = 1'b1;
                    wr_addr = {HIGH_PAGE, req.imm_low};
                end
                OP_LD_HL_SPE: begin
                    sum = cpu.sp + {{8{req.imm_low[7]}}, req.imm_low};
                    byte_sum = {1'b0, cpu.sp[7:0]} + {1'b0, req.imm_low};
                    nib_sum = {1'b0, cpu.sp[3:0]} + {1'b0, req.imm_low[3:0]};
                    cpu.flags = {2'b00, nib_sum[4], byte_sum[8]};
                    {cpu.h, cpu.l} = sum;
                    burst.push_back(reply(KIND_DONE, 16'h0000, 8'h00));
                end
                OP_PUSH_BC, OP_PUSH_DE, OP_PUSH_HL, OP_PUSH_AF: begin
                    case (pair)
                        PAIR_BC: {hi, lo} = bc;
                        PAIR_DE: {hi, lo} = de;
                        PAIR_HL: {hi, lo} = hl;
                        default: {hi, lo} = {cpu.a, cpu.flags, 4'h0};
                    endcase
                    cpu.sp = cpu.sp - 16'd2;
                    burst.push_back(reply(KIND_WRITE, cpu.sp, lo));
                    burst.push_back(reply(KIND_WRITE, cpu.sp + 16'd1, hi));
                    burst.push_back(reply(KIND_DONE, 16'h0000, 8'h00));
                end
                OP_POP_BC, OP_POP_DE, OP_POP_HL, OP_POP_AF: begin
                    pend_kind = PEND_POP;
                    pend_target = {1'b0, pair};
                    reads_owed = 2'd2;
                    burst.push_back(reply(KIND_READ, cpu.sp, 8'h00));
                    burst.push_back(reply(KIND_READ, cpu.sp + 16'd1, 8'h00));
                end
                default: burst.push_back(reply(KIND_ERROR, 16'h0000, 8'h00));
            endcase
        end
        if (is_read) begin
            pend_kind = PEND_LOAD;
            pend_target = rd_dest;
            reads_owed = 2'd1;
            burst.push_back(reply(KIND_READ, rd_addr, 8'h00));
        end
        if (is_write) begin
            burst.push_back(reply(KIND_WRITE, wr_addr, wr_data));
            burst.push_back(reply(KIND_DONE, 16'h0000, 8'h00));
        end
        if (burst.size() != 0)
            burst[burst.size() - 1].last = 1'b1;
        foreach (burst[i])
            replies_due.push_back(burst[i]);
    endtask

    function automatic bit same_result(lsu_out_t x, lsu_out_t y);
        return x.kind === y.kind && x.mem_address === y.mem_address
            && x.write_byte === y.write_byte && x.last === y.last
            && x.acc_out === y.acc_out && x.bc_out === y.bc_out
            && x.de_out === y.de_out && x.hl_out === y.hl_out
            && x.sp_out === y.sp_out && x.flags_out === y.flags_out;
    endfunction

    function automatic string describe(lsu_out_t r);
        return $sformatf("kind=%0d addr=%h wr=%h last=%b a=%h bc=%h de=%h hl=%h sp=%h f=%h",
                         r.kind, r.mem_address, r.write_byte, r.last, r.acc_out,
                         r.bc_out, r.de_out, r.hl_out, r.sp_out, r.flags_out);
    endfunction

    task automatic note_failure(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%t ERROR %s", $realtime, msg);
    endtask

    function automatic int reads_for(logic [7:0] op);
        if (op[7:6] == OP_GRP_LD_RR && op != OP_HALT)
            return (op[2:0] == REG_MEM) ? 1 : 0;
        case (op)
            OP_LD_A_BC, OP_LD_A_DE, OP_LD_A_NN, OP_LDH_A_C, OP_LDH_A_N: return 1;
            OP_POP_BC, OP_POP_DE, OP_POP_HL, OP_POP_AF:                 return 2;
            default:                                                    return 0;
        endcase
    endfunction

    task automatic add_request(logic cmd, logic [7:0] op, logic [7:0] lo, logic [7:0] hi,
                               logic [7:0] data, phase_t ph);
        feed_item_t it;
        it.req.command   = cmd;
        it.req.opcode    = op;
        it.req.imm_low   = lo;
        it.req.imm_high  = hi;
        it.req.read_data = data;
        it.phase         = ph;
        request_feed.push_back(it);
    endtask

    task automatic add_exec(logic [7:0] op, phase_t ph);
        add_request(CMD_EXEC, op, 8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), ph);
    endtask

    task automatic add_data(logic [7:0] data, phase_t ph);
        add_request(CMD_DATA, 8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), data, ph);
    endtask

    // driver
    always @(posedge aclk) begin
        if (s_valid && s_ready)
            step_cpu(s_payload);
        if (aresetn && (!s_valid || s_ready)) begin
            if (request_feed.size() != 0
                && $urandom_range(99) >= gap_pct(request_feed[0].phase)) begin
                s_payload <= request_feed[0].req;
                cur_phase <= request_feed[0].phase;
                request_feed.delete(0);
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        lsu_out_t want;
        if (m_valid && m_ready) begin
            if (replies_due.size() == 0) begin
                note_failure({"unexpected result: ", describe(m_payload)});
            end else begin
                want = replies_due.pop_front();
                if (!same_result(want, m_payload))
                    note_failure({"exp ", describe(want), "\n      got ", describe(m_payload)});
            end
        end
        m_ready <= aresetn && ($urandom_range(99) >= stall_pct(cur_phase));
    end

    initial begin
        phase_t     ph;
        logic [7:0] op;
        int         owed;
        int         roll;

        // directed: field extremes, every addressing form, stack wrap, error cases
        add_request(CMD_EXEC, {OP_GRP_LD_RR, REG_B, REG_MEM}, 8'h00, 8'h00, 8'h00, PH_FLAT);
        add_request(CMD_DATA, 8'h00, 8'h00, 8'h00, 8'hff, PH_FLAT);
        add_request(CMD_EXEC, OP_LD_A_NN, 8'hff, 8'hff, 8'h00, PH_FLAT);
        add_request(CMD_DATA, 8'hff, 8'hff, 8'hff, 8'h80, PH_FLAT);
        add_request(CMD_EXEC, OP_LDH_A_N, 8'hff, 8'h00, 8'hff, PH_FLAT);
        add_request(CMD_DATA, 8'h00, 8'h00, 8'h00, 8'h5a, PH_FLAT);
        add_request(CMD_EXEC, OP_LD_BC_A, 8'h00, 8'h00, 8'h00, PH_FLAT);
        add_request(CMD_EXEC, OP_LD_DE_A, 8'h00, 8'h00, 8'h00, PH_FLAT);
        add_request(CMD_EXEC, OP_LD_NN_A, 8'h00, 8'h00, 8'h00, PH_FLAT);
        add_request(CMD_EXEC, OP_LDH_C_A, 8'h00, 8'h00, 8'h00, PH_FLAT);
        add_request(CMD_EXEC, OP_LDH_N_A, 8'h80, 8'h00, 8'h00, PH_FLAT);
        add_request(CMD_EXEC, {OP_GRP_LD_RR, REG_MEM, REG_B}, 8'h00, 8'h00, 8'h00, PH_FLAT);
        add_request(CMD_EXEC, {OP_GRP_LD_RR, REG_H, REG_B}, 8'h00, 8'h00, 8'h00, PH_FLAT);
        add_request(CMD_EXEC, OP_PUSH_AF, 8'h00, 8'h00, 8'h00, PH_FLAT);
        add_request(CMD_EXEC, OP_LD_HL_SPE, 8'h7f, 8'h00, 8'h00, PH_FLAT);
        add_request(CMD_EXEC, OP_LD_HL_SPE, 8'h80, 8'h00, 8'h00, PH_FLAT);
        add_request(CMD_EXEC, OP_POP_DE, 8'h00, 8'h00, 8'h00, PH_FLAT);
        add_request(CMD_DATA, 8'h00, 8'h00, 8'h00, 8'h34, PH_FLAT);
        add_request(CMD_DATA, 8'h00, 8'h00, 8'h00, 8'h12, PH_FLAT);
        add_request(CMD_EXEC, OP_POP_AF, 8'h00, 8'h00, 8'h00, PH_FLAT);
        add_request(CMD_DATA, 8'h00, 8'h00, 8'h00, 8'hf0, PH_FLAT);
        add_request(CMD_DATA, 8'h00, 8'h00, 8'h00, 8'hff, PH_FLAT);
        add_request(CMD_EXEC, OP_HALT, 8'h00, 8'h00, 8'h00, PH_FLAT);
        add_request(CMD_EXEC, OP_UNUSED_D3, 8'h00, 8'h00, 8'h00, PH_FLAT);
        add_request(CMD_EXEC, OP_LD_A_BC, 8'h00, 8'h00, 8'h00, PH_FLAT);
        add_request(CMD_EXEC, OP_PUSH_HL, 8'h00, 8'h00, 8'h00, PH_FLAT);
        add_request(CMD_DATA, 8'h00, 8'h00, 8'h00, 8'h00, PH_FLAT);
        add_request(CMD_EXEC, OP_POP_BC, 8'h00, 8'h00, 8'h00, PH_FLAT);
        add_request(CMD_DATA, 8'h00, 8'h00, 8'h00, 8'h11, PH_FLAT);
        add_request(CMD_EXEC, OP_LD_A_DE, 8'h00, 8'h00, 8'h00, PH_FLAT);
        add_request(CMD_EXEC, OP_LDH_A_C, 8'h00, 8'h00, 8'h00, PH_FLAT);
        add_request(CMD_DATA, 8'h00, 8'h00, 8'h00, 8'h01, PH_FLAT);

        // random: mostly complete instructions, some noise and cut-short reads
        while (request_feed.size() < NUM_REQUESTS) begin
            ph = phase_t'((request_feed.size() * 4) / (NUM_REQUESTS + 1));
            roll = $urandom_range(99);
            if (roll < 8) begin
                add_data(8'($urandom_range(255)), ph);
            end else if (roll < 16) begin
                add_exec(8'($urandom_range(255)), ph);
            end else begin
                if ($urandom_range(1) == 0)
                    op = {OP_GRP_LD_RR, 3'($urandom_range(7)), 3'($urandom_range(7))};
                else
                    op = LISTED_OPS[$urandom_range(19)];
                if (op == OP_HALT)
                    op = OP_PUSH_DE;
                add_exec(op, ph);
                owed = reads_for(op);
                if (owed != 0 && $urandom_range(19) == 0)
                    owed--;
                repeat (owed) add_data(8'($urandom_range(255)), ph);
            end
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (request_feed.size() != 0 || s_valid || replies_due.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (replies_due.size() != 0)
            note_failure($sformatf("%0d results never arrived", replies_due.size()));

        if (mismatches == 0) begin
            $display("lr35902_load_store_unit regression: pass");
        end else begin
            $display("lr35902_load_store_unit regression: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("lr35902_load_store_unit regression: fail");
        $finish;
    end

endmodule
